// ===== rtl/core/c_subset_lexer_core_defines.svh =====
// Assertion macros used by the lexer core back end (clx_back).
`ifndef C_SUBSET_LEXER_CORE_DEFINES_SVH
`define C_SUBSET_LEXER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CLX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CLX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/clx_pkg.sv =====
// Types, constants and table functions of the lexer core.
`timescale 1ns / 1ps
`default_nettype none
package clx_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned NUM_KW      = 9;
  localparam int unsigned NUM_STATES  = 33;
  localparam logic [7:0]  MAX_LEXEME_LEN = 8'd255;

  localparam logic [5:0] KIND_ID  = 6'd0;
  localparam logic [5:0] KIND_KW0 = 6'd28;
  localparam logic [5:0] KIND_END = 6'd37;
  localparam logic [5:0] KIND_ERR = 6'd38;

  typedef logic [5:0] dfa_state_t;

  localparam dfa_state_t S_NONE     = 6'd0;
  localparam dfa_state_t S_START    = 6'd1;
  localparam dfa_state_t S_BSL      = 6'd2;
  localparam dfa_state_t S_BSL2     = 6'd3;
  localparam dfa_state_t S_BSL_STAR = 6'd4;
  localparam dfa_state_t S_STAR     = 6'd5;
  localparam dfa_state_t S_STAR_BSL = 6'd6;
  localparam dfa_state_t S_SEMI     = 6'd7;
  localparam dfa_state_t S_COMMA    = 6'd8;
  localparam dfa_state_t S_LBRK     = 6'd9;
  localparam dfa_state_t S_RBRK     = 6'd10;
  localparam dfa_state_t S_LPAR     = 6'd11;
  localparam dfa_state_t S_RPAR     = 6'd12;
  localparam dfa_state_t S_LBRC     = 6'd13;
  localparam dfa_state_t S_RBRC     = 6'd14;
  localparam dfa_state_t S_PLUS     = 6'd15;
  localparam dfa_state_t S_MINUS    = 6'd16;
  localparam dfa_state_t S_SLASH    = 6'd17;
  localparam dfa_state_t S_BANG     = 6'd18;
  localparam dfa_state_t S_PCT      = 6'd19;
  localparam dfa_state_t S_EQ       = 6'd20;
  localparam dfa_state_t S_EQEQ     = 6'd21;
  localparam dfa_state_t S_NE       = 6'd22;
  localparam dfa_state_t S_AMP      = 6'd23;
  localparam dfa_state_t S_ANDAND   = 6'd24;
  localparam dfa_state_t S_PIPE     = 6'd25;
  localparam dfa_state_t S_OROR     = 6'd26;
  localparam dfa_state_t S_LT       = 6'd27;
  localparam dfa_state_t S_LE       = 6'd28;
  localparam dfa_state_t S_GT       = 6'd29;
  localparam dfa_state_t S_GE       = 6'd30;
  localparam dfa_state_t S_ID       = 6'd31;
  localparam dfa_state_t S_NUM      = 6'd32;

  localparam logic [5:0] STATE_KIND [NUM_STATES] = '{
    6'd38, 6'd38, 6'd38, 6'd26, 6'd25, 6'd6,  6'd21, 6'd11, 6'd8,  6'd15, 6'd16,
    6'd4,  6'd5,  6'd17, 6'd18, 6'd7,  6'd9,  6'd10, 6'd2,  6'd3,  6'd13, 6'd23,
    6'd19, 6'd38, 6'd20, 6'd38, 6'd27, 6'd12, 6'd22, 6'd14, 6'd24, 6'd0,  6'd1
  };

  localparam logic [7:0] KW_LEN [NUM_KW] = '{
    8'd3, 8'd4, 8'd2, 8'd4, 8'd5, 8'd5, 8'd8, 8'd5, 8'd6
  };

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };

  typedef enum logic [4:0] {
    CL_OTHER, CL_DIGIT, CL_ALPHA, CL_SPACE, CL_NEWLINE, CL_BANG, CL_PERCENT, CL_AMP,
    CL_LPAREN, CL_RPAREN, CL_STAR, CL_PLUS, CL_COMMA, CL_MINUS, CL_SLASH, CL_SEMI,
    CL_LT, CL_EQ, CL_GT, CL_LBRACK, CL_BSLASH, CL_RBRACK, CL_LBRACE, CL_PIPE, CL_RBRACE
  } char_class_e;

  typedef struct packed {
    logic        valid;
    logic        func;
    logic [7:0]  source_byte;
    char_class_e char_class;
  } q_head_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] lexeme_start;
    logic [7:0]  lexeme_length;
    logic        length_overflow;
    logic [31:0] line_count;
    logic        last_result;
  } result_t;

  function automatic logic [5:0] state_kind(dfa_state_t s);
    logic [5:0] k;
    k = KIND_ERR;
    if (s < 6'(NUM_STATES)) begin
      k = STATE_KIND[s];
    end
    return k;
  endfunction

  function automatic dfa_state_t next_state(dfa_state_t s, char_class_e c);
    dfa_state_t n;
    n = S_NONE;
    unique case (s)
      S_START: begin
        unique case (c)
          CL_DIGIT:   n = S_NUM;
          CL_ALPHA:   n = S_ID;
          CL_BANG:    n = S_BANG;
          CL_PERCENT: n = S_PCT;
          CL_AMP:     n = S_AMP;
          CL_LPAREN:  n = S_LPAR;
          CL_RPAREN:  n = S_RPAR;
          CL_STAR:    n = S_STAR;
          CL_PLUS:    n = S_PLUS;
          CL_COMMA:   n = S_COMMA;
          CL_MINUS:   n = S_MINUS;
          CL_SLASH:   n = S_SLASH;
          CL_SEMI:    n = S_SEMI;
          CL_LT:      n = S_LT;
          CL_EQ:      n = S_EQ;
          CL_GT:      n = S_GT;
          CL_LBRACK:  n = S_LBRK;
          CL_BSLASH:  n = S_BSL;
          CL_RBRACK:  n = S_RBRK;
          CL_LBRACE:  n = S_LBRC;
          CL_PIPE:    n = S_PIPE;
          CL_RBRACE:  n = S_RBRC;
          default:    n = S_NONE;
        endcase
      end
      S_BSL: begin
        if (c == CL_STAR) n = S_BSL_STAR;
        else if (c == CL_BSLASH) n = S_BSL2;
      end
      S_STAR:  if (c == CL_BSLASH) n = S_STAR_BSL;
      S_BANG:  if (c == CL_EQ) n = S_NE;
      S_EQ:    if (c == CL_EQ) n = S_EQEQ;
      S_AMP:   if (c == CL_AMP) n = S_ANDAND;
      S_PIPE:  if (c == CL_PIPE) n = S_OROR;
      S_LT:    if (c == CL_EQ) n = S_LE;
      S_GT:    if (c == CL_EQ) n = S_GE;
      S_ID:    if (c == CL_DIGIT || c == CL_ALPHA) n = S_ID;
      S_NUM:   if (c == CL_DIGIT) n = S_NUM;
      default: n = S_NONE;
    endcase
    return n;
  endfunction

  function automatic logic [NUM_KW-1:0] kw_filter(logic [NUM_KW-1:0] cand,
                                                  logic [7:0] pos, logic [7:0] b);
    logic [NUM_KW-1:0] r;
    r = cand;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!(pos < KW_LEN[k] && KW_TEXT[k][pos[2:0]] == b)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/clx_if.sv =====
// Valid/ready stream interfaces for source items and tokens.
`timescale 1ns / 1ps
`default_nettype none
interface clx_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] source_byte;

  modport source (output valid, func, source_byte, input ready);
  modport sink   (input valid, func, source_byte, output ready);
endinterface

interface clx_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] lexeme_start;
  logic [7:0]  lexeme_length;
  logic        length_overflow;
  logic [31:0] line_count;
  logic        last_result;

  modport source (output valid, token_kind, lexeme_start, lexeme_length, length_overflow,
                  line_count, last_result, input ready);
  modport sink   (input valid, token_kind, lexeme_start, lexeme_length, length_overflow,
                  line_count, last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/c_subset_lexer_core.sv =====
// Top level of the longest-match lexer core for a small C subset.
//
// Channels: in_i carries one item per transfer, a source byte (func 0) or an
// end-of-input mark (func 1). out_o carries token results; each input item
// gives zero, one or two results, and last_result marks the final one.
// Path: an item transferred in is written into the queue and its result is then
// loaded into the output register, when the queue is empty and out_o is ready.
// Throughput: one item per cycle while out_o is ready; an item with two results
// holds the back end until the spare slot behind the output register is free.
// A four-entry queue between classifier and DFA absorbs short stalls, so in_i
// keeps taking items while a finished token waits on out_o.
// Reset: rst_ni clears the queue, returns the DFA to the start state and zeroes
// the byte and newline counters; an unknown byte stays an error until reset.
// Stall: while a result waits on a low out_o.ready the back end halts, the queue
// fills and in_i.ready drops once all four entries are taken; no result is lost.
`timescale 1ns / 1ps
`default_nettype none
module c_subset_lexer_core
  import clx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clx_in_if.sink    in_i,
  clx_out_if.source out_o
);

  q_head_t head;
  logic    pop;

  clx_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  clx_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/clx_front.sv =====
// Front end: byte classification and the input item queue.
`timescale 1ns / 1ps
`default_nettype none
module clx_front
  import clx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clx_in_if.sink    in_i,
  output q_head_t   head_o,
  input  wire logic pop_i
);

  typedef struct packed {
    logic        func;
    logic [7:0]  source_byte;
    char_class_e char_class;
  } q_entry_t;

  q_entry_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]     count_q;
  q_entry_t              entry;
  logic                  push;
  logic                  pop;

  function automatic char_class_e classify(logic [7:0] b);
    char_class_e c;
    c = CL_OTHER;
    if (b >= "0" && b <= "9") begin
      c = CL_DIGIT;
    end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") begin
      c = CL_ALPHA;
    end else begin
      unique case (b)
        " ", "\t": c = CL_SPACE;
        "\n":      c = CL_NEWLINE;
        "!":       c = CL_BANG;
        "%":       c = CL_PERCENT;
        "&":       c = CL_AMP;
        "(":       c = CL_LPAREN;
        ")":       c = CL_RPAREN;
        "*":       c = CL_STAR;
        "+":       c = CL_PLUS;
        ",":       c = CL_COMMA;
        "-":       c = CL_MINUS;
        "/":       c = CL_SLASH;
        ";":       c = CL_SEMI;
        "<":       c = CL_LT;
        "=":       c = CL_EQ;
        ">":       c = CL_GT;
        "[":       c = CL_LBRACK;
        "\\":      c = CL_BSLASH;
        "]":       c = CL_RBRACK;
        "{":       c = CL_LBRACE;
        "|":       c = CL_PIPE;
        "}":       c = CL_RBRACE;
        default:   c = CL_OTHER;
      endcase
    end
    return c;
  endfunction

  assign in_i.ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (count_q != '0);

  assign entry.func        = in_i.func;
  assign entry.source_byte = in_i.source_byte;
  assign entry.char_class  = classify(in_i.source_byte);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign head_o.valid       = (count_q != '0);
  assign head_o.func        = mem_q[rd_ptr_q].func;
  assign head_o.source_byte = mem_q[rd_ptr_q].source_byte;
  assign head_o.char_class  = mem_q[rd_ptr_q].char_class;

endmodule
`default_nettype wire

// ===== rtl/core/clx_back.sv =====
// Back end: DFA step, keyword match, token results and output registers.
`timescale 1ns / 1ps
`default_nettype none
`include "c_subset_lexer_core_defines.svh"
module clx_back
  import clx_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_head_t head_i,
  output logic         pop_o,
  clx_out_if.source    out_o
);

  dfa_state_t        dfa_state_q, dfa_state_d;
  logic [7:0]        pend_len_q, pend_len_d;
  logic              pend_ovf_q, pend_ovf_d;
  logic [31:0]       pend_start_q, pend_start_d;
  logic [31:0]       byte_pos_q, byte_pos_d;
  logic [31:0]       nl_total_q, nl_total_d;
  logic [NUM_KW-1:0] kw_cand_q, kw_cand_d;
  logic              stuck_q, stuck_d;

  logic              out_valid_q, sec_valid_q;
  result_t           out_q, sec_q;

  result_t           close_res, res_a, res_b, err_res, end_res;
  logic              a_v, b_v;
  logic              step;
  logic              restart;
  dfa_state_t        nx, nx_start;
  logic [5:0]        close_kind;

  assign step  = head_i.valid && !sec_valid_q && (!out_valid_q || out_o.ready);
  assign pop_o = step;

  always_comb begin
    close_kind = state_kind(dfa_state_q);
    if (close_kind == KIND_ID && !pend_ovf_q) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (kw_cand_q[k] && KW_LEN[k] == pend_len_q) begin
          close_kind = KIND_KW0 + 6'(k);
        end
      end
    end
    close_res = '{close_kind, pend_start_q, pend_len_q, pend_ovf_q, nl_total_q, 1'b0};
    end_res   = '{KIND_END, byte_pos_q, 8'd0, 1'b0, nl_total_q, 1'b0};
    err_res   = '{KIND_ERR, byte_pos_q, 8'd1, 1'b0, nl_total_q, 1'b0};
  end

  always_comb begin
    dfa_state_d  = dfa_state_q;
    pend_len_d   = pend_len_q;
    pend_ovf_d   = pend_ovf_q;
    pend_start_d = pend_start_q;
    byte_pos_d   = byte_pos_q;
    nl_total_d   = nl_total_q;
    kw_cand_d    = kw_cand_q;
    stuck_d      = stuck_q;
    res_a        = close_res;
    res_b        = end_res;
    a_v          = 1'b0;
    b_v          = 1'b0;
    restart      = 1'b0;
    nx           = next_state(dfa_state_q, head_i.char_class);
    nx_start     = next_state(S_START, head_i.char_class);

    if (head_i.func) begin
      a_v = 1'b1;
      if (stuck_q) begin
        res_a = end_res;
        res_a.token_kind = KIND_ERR;
      end else if (dfa_state_q != S_START) begin
        b_v         = 1'b1;
        dfa_state_d = S_START;
      end else begin
        res_a = end_res;
      end
    end else if (!stuck_q) begin
      if (dfa_state_q == S_START) begin
        restart = 1'b1;
      end else if (nx != S_NONE) begin
        kw_cand_d   = kw_filter(kw_cand_q, pend_len_q, head_i.source_byte);
        if (pend_len_q >= MAX_LEXEME_LEN) pend_ovf_d = 1'b1;
        else pend_len_d = pend_len_q + 8'd1;
        dfa_state_d = nx;
        byte_pos_d  = byte_pos_q + 32'd1;
      end else begin
        a_v         = 1'b1;
        dfa_state_d = S_START;
        restart     = 1'b1;
      end
      if (restart) begin
        if (head_i.char_class == CL_SPACE || head_i.char_class == CL_NEWLINE) begin
          if (head_i.char_class == CL_NEWLINE) nl_total_d = nl_total_q + 32'd1;
          byte_pos_d = byte_pos_q + 32'd1;
        end else if (nx_start == S_NONE) begin
          if (a_v) begin
            res_b = err_res;
            b_v   = 1'b1;
          end else begin
            res_a = err_res;
            a_v   = 1'b1;
          end
          stuck_d = 1'b1;
        end else begin
          pend_start_d = byte_pos_q;
          pend_len_d   = 8'd1;
          pend_ovf_d   = 1'b0;
          kw_cand_d    = kw_filter('1, 8'd0, head_i.source_byte);
          dfa_state_d  = nx_start;
          byte_pos_d   = byte_pos_q + 32'd1;
        end
      end
    end

    if (b_v) res_b.last_result = 1'b1;
    else res_a.last_result = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfa_state_q  <= S_START;
      pend_len_q   <= '0;
      pend_ovf_q   <= 1'b0;
      pend_start_q <= '0;
      byte_pos_q   <= '0;
      nl_total_q   <= '0;
      kw_cand_q    <= '1;
      stuck_q      <= 1'b0;
    end else if (step) begin
      dfa_state_q  <= dfa_state_d;
      pend_len_q   <= pend_len_d;
      pend_ovf_q   <= pend_ovf_d;
      pend_start_q <= pend_start_d;
      byte_pos_q   <= byte_pos_d;
      nl_total_q   <= nl_total_d;
      kw_cand_q    <= kw_cand_d;
      stuck_q      <= stuck_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= a_v;
      sec_valid_q <= b_v;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_q <= sec_valid_q;
      sec_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res_a;
      sec_q <= res_b;
    end else if (out_valid_q && out_o.ready && sec_valid_q) begin
      out_q <= sec_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.token_kind      = out_q.token_kind;
  assign out_o.lexeme_start    = out_q.lexeme_start;
  assign out_o.lexeme_length   = out_q.lexeme_length;
  assign out_o.length_overflow = out_q.length_overflow;
  assign out_o.line_count      = out_q.line_count;
  assign out_o.last_result     = out_q.last_result;

  `CLX_ASSERT_IMP(a_sec_behind_out, sec_valid_q, out_valid_q, "second result without first")
  `CLX_ASSERT_NXT(a_stuck_sticky, stuck_q, stuck_q, "stuck error cleared without reset")
  `CLX_ASSERT_IMP(a_stuck_at_start, stuck_q, dfa_state_q == S_START, "stuck outside start")
  `CLX_ASSERT_IMP(a_state_legal, 1'b1, dfa_state_q != S_NONE && dfa_state_q <= S_NUM,
                  "DFA state out of range")
  `CLX_ASSERT_IMP(a_no_step_when_blocked, sec_valid_q, !pop_o, "queue popped while blocked")

endmodule
`default_nettype wire
